// ----- rtl/ssm_pkg.sv -----
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and codes for the sample statistics monitor
// Result status codes, request kinds and the controller state type.
// ----------------------------------------------------------------------------
package ssm_pkg;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // request kinds
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // controller state, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

endpackage

// ----- rtl/sample_statistics_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// sample_statistics_monitor_unit: min / max / mean / threshold counts
// Stores up to CAPACITY signed 16-bit samples in an on-chip memory and keeps
// running count, sum, min and max. A query walks the memory to count samples
// below a Q.8 threshold while a serial divider forms the Q.8 mean.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  -------   ---------  -------------------  ----------------------------------
//  request   in         i_valid / o_ready    i_action, i_sample, i_threshold
//  result    out        o_valid / i_ready    o_status, o_maximum, o_minimum,
//                                            o_mean, o_count_under,
//                                            o_count_above, o_sample_count
//
//  Requests: an add, an empty query and a full add are each answered in the
//  cycle after they are taken; adds run back to back as long as the result
//  register drains. A query ends when both the memory walk over the N stored
//  samples (one read port, one entry per cycle) and the bit-serial divider
//  over a DW = clog2(CAPACITY+1) + 24 bit dividend (35 at the default) are
//  done; the two run side by side.
//  Reset: synchronous, active low; no clearing pass, the memory is only read
//  below the fill count. Stalls: o_ready stays low while a query runs or
//  while an untaken result sits in the output register.
//
module sample_statistics_monitor_unit #(
    parameter int CAPACITY = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_action,
    input  logic signed [15:0] i_sample,
    input  logic signed [23:0] i_threshold,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [15:0] o_maximum,
    output logic signed [15:0] o_minimum,
    output logic signed [23:0] o_mean,
    output logic [10:0]        o_count_under,
    output logic [10:0]        o_count_above,
    output logic [10:0]        o_sample_count
);
    import ssm_pkg::*;

    localparam int AW  = $clog2(CAPACITY);       // memory address width
    localparam int CW  = $clog2(CAPACITY + 1);   // fill count width
    localparam int SW  = CW + 16;                // running sum width
    localparam int DW  = SW + 8;                 // dividend width (sum * 256)
    localparam int DCW = $clog2(DW + 1);         // divider step counter width
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // ---------------- state ----------------
    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic signed [SW-1:0]  r_sum;
    logic signed [15:0]    r_min;
    logic signed [15:0]    r_max;

    // sample memory, one write / one registered read per cycle
    logic [15:0]           r_mem [CAPACITY];
    logic [15:0]           r_rd_data;
    logic                  r_rd_vld;

    // query walk
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_under;
    logic signed [23:0]    r_thr;

    // restoring divider: |sum| * 256 / count
    logic [CW-1:0]         r_rem;
    logic [DW-1:0]         r_quo;
    logic                  r_neg;
    logic [DCW-1:0]        r_dcnt;

    // result register
    logic                  r_out_valid;
    logic [1:0]            r_status;
    logic signed [15:0]    r_omax;
    logic signed [15:0]    r_omin;
    logic signed [23:0]    r_omean;
    logic [CW-1:0]         r_ounder;
    logic [CW-1:0]         r_oabove;
    logic [CW-1:0]         r_ocount;

    // ---------------- control ----------------
    logic                  w_accept;
    logic                  w_add;
    logic                  w_full;
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic                  w_walk_done;
    logic                  w_div_done;
    logic                  w_finish;
    logic                  w_below;
    logic                  w_out_set;

    assign o_ready  = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign w_accept = i_valid && o_ready;
    assign w_add    = (i_action == ACT_ADD);
    assign w_full   = (r_count >= CAP_C);
    assign w_wr_en  = w_accept && w_add && !w_full;

    assign w_rd_en     = (r_state == S_RUN) && (r_idx < r_count);
    assign w_walk_done = (r_idx == r_count) && !r_rd_vld;
    assign w_div_done  = (r_dcnt == '0);
    assign w_finish    = (r_state == S_RUN) && w_walk_done && w_div_done;

    // result register loads on an add or an empty query, or at the end of a query
    assign w_out_set = (w_accept && (w_add || (r_count == '0))) || w_finish;

    // sample * 256 < threshold, both as 24-bit signed Q.8
    assign w_below = $signed({r_rd_data, 8'h00}) < r_thr;

    // ---------------- running update on add ----------------
    logic signed [SW-1:0]  n_sum;
    logic signed [15:0]    n_min;
    logic signed [15:0]    n_max;
    logic [CW-1:0]         n_count;

    always_comb begin
        n_sum   = r_sum + {{(SW-16){i_sample[15]}}, i_sample};
        n_count = r_count + CW'(1);
        n_min   = ((r_count == '0) || (i_sample < r_min)) ? i_sample : r_min;
        n_max   = ((r_count == '0) || (i_sample > r_max)) ? i_sample : r_max;
    end

    // ---------------- divider step ----------------
    logic [CW:0]           n_rem_sh;
    logic                  n_qbit;
    logic [CW-1:0]         n_rem;
    logic [DW-1:0]         n_quo;
    logic [SW-1:0]         n_mag;
    logic [DW-1:0]         n_quo_neg;

    always_comb begin
        n_rem_sh  = {r_rem, r_quo[DW-1]};
        n_qbit    = (n_rem_sh >= {1'b0, r_count});
        n_rem     = n_qbit ? CW'(n_rem_sh - {1'b0, r_count}) : n_rem_sh[CW-1:0];
        n_quo     = {r_quo[DW-2:0], n_qbit};
        n_mag     = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
        n_quo_neg = ~r_quo + DW'(1);
    end

    // ---------------- memory ----------------
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[AW-1:0]] <= i_sample;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    // ---------------- control and datapath ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_rd_vld    <= 1'b0;
            r_idx       <= '0;
            r_under     <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_set) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_rd_vld <= w_rd_en;

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_omax   <= '0;
                        r_omin   <= '0;
                        r_omean  <= '0;
                        r_ounder <= '0;
                        r_oabove <= '0;
                        if (w_add) begin
                            if (w_full) begin
                                r_status <= ST_FULL;
                                r_ocount <= r_count;
                            end else begin
                                r_status <= ST_OK;
                                r_ocount <= n_count;
                                r_count  <= n_count;
                                r_sum    <= n_sum;
                                r_min    <= n_min;
                                r_max    <= n_max;
                            end
                        end else if (r_count == '0) begin
                            r_status    <= ST_EMPTY;
                            r_ocount    <= '0;
                        end else begin
                            // start the walk and the divider together
                            r_state <= S_RUN;
                            r_thr   <= i_threshold;
                            r_idx   <= '0;
                            r_under <= '0;
                            r_rem   <= '0;
                            r_quo   <= {n_mag, 8'h00};
                            r_neg   <= r_sum[SW-1];
                            r_dcnt  <= DCW'(DW);
                        end
                    end
                end
                S_RUN: begin
                    if (w_rd_en) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_rd_vld && w_below) begin
                        r_under <= r_under + CW'(1);
                    end
                    if (!w_div_done) begin
                        r_rem  <= n_rem;
                        r_quo  <= n_quo;
                        r_dcnt <= r_dcnt - DCW'(1);
                    end
                    if (w_finish) begin
                        r_state     <= S_IDLE;
                        r_status    <= ST_OK;
                        r_omax      <= r_max;
                        r_omin      <= r_min;
                        r_omean     <= r_neg ? n_quo_neg[23:0] : r_quo[23:0];
                        r_ounder    <= r_under;
                        r_oabove    <= r_count - r_under;
                        r_ocount    <= r_count;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------- outputs ----------------
    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_maximum      = r_omax;
    assign o_minimum      = r_omin;
    assign o_mean         = r_omean;
    assign o_count_under  = 11'(r_ounder);
    assign o_count_above  = 11'(r_oabove);
    assign o_sample_count = 11'(r_ocount);

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("fill count above capacity");

    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (!o_ready && !r_out_valid))
        else $error("request taken or result pending during a query");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_add && w_full) |=>
        (r_count == $past(r_count) && r_status == ST_FULL && r_out_valid))
        else $error("add on full store changed state");

    a_under_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_under <= r_idx && r_idx <= r_count))
        else $error("walk counters out of order");

endmodule

// ----- dv/sample_statistics_monitor_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sample_statistics_monitor_unit_tb: self-checking bench for the stats monitor
// Drives add and query requests with random idling on both channels. A
// scoreboard keeps its own copy of the sample store and running statistics,
// predicts every result, and compares each returned transfer field by field.
// ----------------------------------------------------------------------------
module sample_statistics_monitor_unit_tb;
    import ssm_pkg::*;

    localparam int CAPACITY   = 1024;
    localparam int CLK_PERIOD = 12;
    localparam int RAND_ITEMS = 850;

    // one result transfer, as the block presents it
    typedef struct {
        logic [1:0]         status;
        logic signed [15:0] maximum;
        logic signed [15:0] minimum;
        logic signed [23:0] mean;
        logic [10:0]        count_under;
        logic [10:0]        count_above;
        logic [10:0]        sample_count;
    } stats_report_t;

    // Predicts the block from accepted requests and holds the reports still
    // owed by it, oldest first.
    class stats_scoreboard;
        logic signed [15:0] samples [CAPACITY];
        int                 fill;
        longint             sum_acc;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        stats_report_t      expected_reports [$];
        int                 errors;

        function new();
            fill    = 0;
            sum_acc = 0;
            lo      = '0;
            hi      = '0;
            errors  = 0;
        endfunction

        function void note_request(logic act, logic signed [15:0] smp,
                                   logic signed [23:0] thr);
            stats_report_t r;
            int            below;
            longint        q;
            r = '{default: '0};
            if (act == ACT_ADD) begin
                if (fill >= CAPACITY) begin
                    // store full: sample dropped, nothing else moves
                    r.status = ST_FULL;
                end else begin
                    samples[fill] = smp;
                    if (fill == 0 || smp < lo) lo = smp;
                    if (fill == 0 || smp > hi) hi = smp;
                    sum_acc += smp;
                    fill++;
                    r.status = ST_OK;
                end
            end else if (fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                below = 0;
                for (int i = 0; i < fill; i++)
                    if (longint'(samples[i]) * 256 < longint'(thr)) below++;
                q = (sum_acc * 256) / fill;     // truncates toward zero
                r.status      = ST_OK;
                r.maximum     = hi;
                r.minimum     = lo;
                r.mean        = q[23:0];
                r.count_under = below[10:0];
                r.count_above = 11'(fill - below);
            end
            r.sample_count = fill[10:0];
            expected_reports.push_back(r);
        endfunction

        function void cmp_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(stats_report_t got);
            stats_report_t want;
            if (expected_reports.size() == 0) begin
                $error("result transfer with no request outstanding");
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            cmp_field("status",       want.status,       got.status);
            cmp_field("maximum",      want.maximum,      got.maximum);
            cmp_field("minimum",      want.minimum,      got.minimum);
            cmp_field("mean",         want.mean,         got.mean);
            cmp_field("count_under",  want.count_under,  got.count_under);
            cmp_field("count_above",  want.count_above,  got.count_above);
            cmp_field("sample_count", want.sample_count, got.sample_count);
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_ready;
    logic               i_action    = ACT_ADD;
    logic signed [15:0] i_sample    = '0;
    logic signed [23:0] i_threshold = '0;
    logic               o_valid;
    logic               i_ready     = 1'b0;
    logic [1:0]         o_status;
    logic signed [15:0] o_maximum;
    logic signed [15:0] o_minimum;
    logic signed [23:0] o_mean;
    logic [10:0]        o_count_under;
    logic [10:0]        o_count_above;
    logic [10:0]        o_sample_count;

    stats_scoreboard sb = new();

    // steady: both sides stop idling; hold_req: receiver starts a long stall
    bit steady   = 1'b0;
    bit hold_req = 1'b0;

    sample_statistics_monitor_unit #(.CAPACITY(CAPACITY)) dut (.*);

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Monitor: everything is sampled at the rising edge, while inputs only
    // move on the falling edge, so each transfer is seen exactly once.
    always @(posedge i_clk) begin
        stats_report_t got;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got.status       = o_status;
                got.maximum      = o_maximum;
                got.minimum      = o_minimum;
                got.mean         = o_mean;
                got.count_under  = o_count_under;
                got.count_above  = o_count_above;
                got.sample_count = o_sample_count;
                sb.check_result(got);
            end
            if (i_valid && o_ready)
                sb.note_request(i_action, i_sample, i_threshold);
        end
    end

    // Result side backpressure. A hold request parks i_ready low, so the output
    // register fills and o_ready falls while the sender keeps its request up.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
                i_ready  <= 1'b0;
            end else begin
                i_ready <= steady || ($urandom_range(0, 99) >= 37);
            end
        end
    end

    // One request transfer. Random gaps before it; valid then holds with a
    // fixed payload until the block takes it.
    task automatic send_req(input logic act, input logic [15:0] smp,
                            input logic [23:0] thr);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 37) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= act;
        i_sample    <= smp;
        i_threshold <= thr;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and sit until every owed result has come back.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_reports.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'(int'($urandom_range(0, 600)) - 300);
            3:       return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    // Thresholds: full range, extremes, or right on a stored sample's Q.8
    // value give or take one LSB so the strict compare gets exercised.
    function automatic logic [23:0] pick_threshold();
        int k;
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2, 3: begin
                if (sb.fill == 0) return 24'($urandom);
                k = $urandom_range(0, sb.fill - 1);
                return {sb.samples[k], 8'h00} + 24'($urandom_range(0, 2)) - 24'd1;
            end
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: empty store, first sample, extremes, boundaries
        send_req(ACT_QUERY, 16'h0000, 24'h000000);  // empty query
        send_req(ACT_ADD,   16'sh7FFF, 24'h000000); // first sample sets min/max
        send_req(ACT_QUERY, 16'h0000, 24'h7FFF00);  // threshold equal to sample
        send_req(ACT_QUERY, 16'h0000, 24'h7FFF01);  // one LSB above it
        send_req(ACT_ADD,   16'sh8000, 24'hFFFFFF);
        send_req(ACT_ADD,   16'h0000, 24'h000000);
        send_req(ACT_ADD,   16'hFFFF, 24'h000000);
        send_req(ACT_QUERY, 16'hFFFF, 24'h7FFFFF);  // largest threshold
        send_req(ACT_QUERY, 16'hFFFF, 24'h800000);  // smallest threshold
        send_req(ACT_QUERY, 16'h0000, 24'h000000);
        send_req(ACT_QUERY, 16'h0000, 24'hFFFF00);  // exactly -1.0
        send_req(ACT_ADD,   16'h0001, 24'h000000);
        send_req(ACT_ADD,   16'sh7FFF, 24'h000000); // repeat of the max
        send_req(ACT_QUERY, 16'h0000, 24'h000001);
        send_req(ACT_ADD,   16'sh8000, 24'h000000); // repeat of the min
        send_req(ACT_QUERY, 16'h5555, 24'hAAAAAA);

        // sender pauses until the block has returned everything
        drain();

        // --- random traffic, mostly adds
        for (int n = 0; n < RAND_ITEMS; n++) begin
            steady = (n >= 200 && n < 400);
            if (n == 500) hold_req = 1'b1;
            if ($urandom_range(0, 9) == 0)
                send_req(ACT_QUERY, 16'($urandom), pick_threshold());
            else
                send_req(ACT_ADD, pick_sample(), 24'($urandom));
        end
        steady = 1'b0;

        // --- top the store up to capacity, then hit the full case
        while (sb.fill < CAPACITY) begin
            if ($urandom_range(0, 63) == 0)
                send_req(ACT_QUERY, 16'($urandom), pick_threshold());
            else
                send_req(ACT_ADD, pick_sample(), 24'($urandom));
        end
        for (int n = 0; n < 16; n++) begin
            if (n % 4 == 3)
                send_req(ACT_QUERY, 16'($urandom), pick_threshold());
            else
                send_req(ACT_ADD, pick_sample(), 24'($urandom));
        end

        drain();
        repeat (64) @(posedge i_clk);   // catch any stray result transfer
        if (sb.errors == 0 && sb.expected_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #(CLK_PERIOD * 3000000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
